>>> hw/rtl/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and codes of the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

   localparam int BYTE_W  = 8;
   localparam int ERR_W   = 4;
   localparam int MAX_OUT = 4;
   localparam int CNT_W   = 3;
   localparam int IDX_W   = 2;

   localparam logic [ERR_W-1:0] ERR_OK           = 4'd0;
   localparam logic [ERR_W-1:0] ERR_NO_BACKSLASH = 4'd1;
   localparam logic [ERR_W-1:0] ERR_INCOMPLETE   = 4'd2;
   localparam logic [ERR_W-1:0] ERR_BAD_UTF8     = 4'd3;
   localparam logic [ERR_W-1:0] ERR_BAD_ESCAPE   = 4'd4;
   localparam logic [ERR_W-1:0] ERR_HEX_SHORT    = 4'd5;
   localparam logic [ERR_W-1:0] ERR_BAD_HEX      = 4'd6;
   localparam logic [ERR_W-1:0] ERR_UNI_SHORT    = 4'd7;
   localparam logic [ERR_W-1:0] ERR_BAD_UNI_HEX  = 4'd8;
   localparam logic [ERR_W-1:0] ERR_SURROGATE    = 4'd9;
   localparam logic [ERR_W-1:0] ERR_RANGE        = 4'd10;

   typedef struct packed {
      logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]               count;
      logic                           consumed;
      logic                           done;
      logic [ERR_W-1:0]               err;
   } sed_result_type;

endpackage

>>> hw/rtl/sed_decode.sv
// ----------------------------------------------------------------------------
// sed_decode
// Escape sequence state and per-byte decode into up to four output bytes.
// ----------------------------------------------------------------------------
module sed_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [sed_pkg::BYTE_W-1:0]   in_byte,
   input  logic                         end_of_source,
   output sed_pkg::sed_result_type      res
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_AFTER = 3'd1;
   localparam logic [2:0] PH_CR    = 3'd2;
   localparam logic [2:0] PH_HEX   = 3'd3;
   localparam logic [2:0] PH_UNI   = 3'd4;
   localparam logic [2:0] PH_OCT   = 3'd5;
   localparam logic [2:0] PH_UTF8  = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  seen_ff, seen_in;
   logic [3:0]  need_ff, need_in;
   logic [1:0]  rem_ff, rem_in;
   logic [7:0]  held_ff [4];
   logic        held_we;
   logic [1:0]  held_wa;

   logic [4:0]  hex_d;
   logic [31:0] acc_hex;
   logic [3:0]  seen_inc;
   logic [10:0] oct_next;
   logic [7:0]  lo, hi;
   logic [1:0]  more;
   logic        is_oct;

   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
      else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
         r = {1'b1, b[3:0] + 4'd9};
      return r;
   endfunction

   assign hex_d    = hex_value(in_byte);
   assign acc_hex  = {acc_ff[27:0], hex_d[3:0]};
   assign seen_inc = seen_ff + 4'd1;
   assign oct_next = {acc_ff[7:0], in_byte[2:0]};
   assign is_oct   = (in_byte[7:3] == 5'b00110);

   always_comb begin
      res      = '0;
      phase_in = phase_ff;
      acc_in   = acc_ff;
      seen_in  = seen_ff;
      need_in  = need_ff;
      rem_in   = rem_ff;
      held_we  = 1'b0;
      held_wa  = seen_ff[1:0];
      lo       = 8'h80;
      hi       = 8'hBF;
      more     = 2'd0;
      unique case (phase_ff) inside
         PH_IDLE: begin
            if (end_of_source || in_byte != 8'h5C) begin
               res.err  = sed_pkg::ERR_NO_BACKSLASH;
               res.done = 1'b1;
            end else begin
               res.consumed = 1'b1;
               phase_in     = PH_AFTER;
            end
         end
         PH_AFTER: begin
            if (end_of_source) begin
               res.err  = sed_pkg::ERR_INCOMPLETE;
               res.done = 1'b1;
            end else begin
               res.consumed = 1'b1;
               if (in_byte == 8'h0A) begin
                  res.done = 1'b1;
               end else if (in_byte == 8'h0D) begin
                  phase_in = PH_CR;
               end else if (in_byte[7]) begin
                  if (in_byte >= 8'hC2 && in_byte <= 8'hDF) more = 2'd1;
                  else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) more = 2'd2;
                  else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) more = 2'd3;
                  if (more == 2'd0) begin
                     res.err      = sed_pkg::ERR_BAD_UTF8;
                     res.done     = 1'b1;
                     res.consumed = 1'b0;
                  end else begin
                     held_we  = 1'b1;
                     held_wa  = 2'd0;
                     seen_in  = 4'd1;
                     rem_in   = more;
                     phase_in = PH_UTF8;
                  end
               end else if (in_byte == 8'h78) begin
                  phase_in = PH_HEX;
                  acc_in   = '0;
                  seen_in  = '0;
                  need_in  = 4'd2;
               end else if (in_byte == 8'h75 || in_byte == 8'h55) begin
                  phase_in = PH_UNI;
                  acc_in   = '0;
                  seen_in  = '0;
                  need_in  = (in_byte == 8'h75) ? 4'd4 : 4'd8;
               end else if (is_oct) begin
                  phase_in = PH_OCT;
                  acc_in   = {29'd0, in_byte[2:0]};
                  seen_in  = 4'd1;
               end else begin
                  res.done  = 1'b1;
                  res.count = 3'd1;
                  unique case (in_byte) inside
                     8'h6E: res.bytes[0] = 8'h0A;
                     8'h74: res.bytes[0] = 8'h09;
                     8'h72: res.bytes[0] = 8'h0D;
                     8'h62: res.bytes[0] = 8'h08;
                     8'h66: res.bytes[0] = 8'h0C;
                     8'h76: res.bytes[0] = 8'h0B;
                     8'h61: res.bytes[0] = 8'h07;
                     8'h5C, 8'h27, 8'h22, 8'h3F: res.bytes[0] = in_byte;
                     default: begin
                        res.count = 3'd0;
                        res.err   = sed_pkg::ERR_BAD_ESCAPE;
                     end
                  endcase
               end
            end
         end
         PH_CR: begin
            res.done = 1'b1;
            if (!end_of_source && in_byte == 8'h0A) res.consumed = 1'b1;
            else res.err = sed_pkg::ERR_BAD_ESCAPE;
         end
         PH_HEX, PH_UNI: begin
            if (end_of_source) begin
               res.err  = (phase_ff == PH_HEX) ? sed_pkg::ERR_HEX_SHORT
                                               : sed_pkg::ERR_UNI_SHORT;
               res.done = 1'b1;
            end else if (!hex_d[4]) begin
               res.err  = (phase_ff == PH_HEX) ? sed_pkg::ERR_BAD_HEX
                                               : sed_pkg::ERR_BAD_UNI_HEX;
               res.done = 1'b1;
            end else begin
               res.consumed = 1'b1;
               acc_in       = acc_hex;
               seen_in      = seen_inc;
               if (seen_inc >= need_ff) begin
                  res.done = 1'b1;
                  if (phase_ff == PH_HEX) begin
                     res.bytes[0] = acc_hex[7:0];
                     res.count    = 3'd1;
                  end else if (acc_hex >= 32'hD800 && acc_hex <= 32'hDFFF) begin
                     res.err = sed_pkg::ERR_SURROGATE;
                  end else if (acc_hex > 32'h0010_FFFF) begin
                     res.err = sed_pkg::ERR_RANGE;
                  end else if (acc_hex < 32'h80) begin
                     res.bytes[0] = acc_hex[7:0];
                     res.count    = 3'd1;
                  end else if (acc_hex < 32'h800) begin
                     res.bytes[0] = {3'b110, acc_hex[10:6]};
                     res.bytes[1] = {2'b10, acc_hex[5:0]};
                     res.count    = 3'd2;
                  end else if (acc_hex < 32'h10000) begin
                     res.bytes[0] = {4'b1110, acc_hex[15:12]};
                     res.bytes[1] = {2'b10, acc_hex[11:6]};
                     res.bytes[2] = {2'b10, acc_hex[5:0]};
                     res.count    = 3'd3;
                  end else begin
                     res.bytes[0] = {5'b11110, acc_hex[20:18]};
                     res.bytes[1] = {2'b10, acc_hex[17:12]};
                     res.bytes[2] = {2'b10, acc_hex[11:6]};
                     res.bytes[3] = {2'b10, acc_hex[5:0]};
                     res.count    = 3'd4;
                  end
               end
            end
         end
         PH_OCT: begin
            res.done = 1'b1;
            if (!end_of_source && is_oct && oct_next[10:8] == 3'd0) begin
               acc_in       = {21'd0, oct_next};
               seen_in      = seen_inc;
               res.consumed = 1'b1;
               if (seen_inc < 4'd3) res.done = 1'b0;
            end
            if (res.done) begin
               res.bytes[0] = acc_in[7:0];
               res.count    = 3'd1;
            end
         end
         PH_UTF8: begin
            if (seen_ff == 4'd1) begin
               if (held_ff[0] == 8'hE0) lo = 8'hA0;
               else if (held_ff[0] == 8'hED) hi = 8'h9F;
               else if (held_ff[0] == 8'hF0) lo = 8'h90;
               else if (held_ff[0] == 8'hF4) hi = 8'h8F;
            end
            if (end_of_source || in_byte < lo || in_byte > hi ||
                seen_ff >= 4'd4 || rem_ff == 2'd0) begin
               res.err  = sed_pkg::ERR_BAD_UTF8;
               res.done = 1'b1;
            end else begin
               res.consumed = 1'b1;
               held_we      = 1'b1;
               seen_in      = seen_inc;
               rem_in       = rem_ff - 2'd1;
               if (rem_ff == 2'd1) begin
                  res.done = 1'b1;
                  res.count = seen_inc[2:0];
                  for (int k = 0; k < sed_pkg::MAX_OUT; k++) begin
                     if (k[1:0] == seen_ff[1:0]) res.bytes[k] = in_byte;
                     else if (k < int'(seen_ff)) res.bytes[k] = held_ff[k];
                  end
               end
            end
         end
         default: begin
            res.done = 1'b1;
         end
      endcase
      if (res.done) begin
         phase_in = PH_IDLE;
         acc_in   = '0;
         seen_in  = '0;
         need_in  = '0;
         rem_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         seen_ff  <= '0;
         need_ff  <= '0;
         rem_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         seen_ff  <= seen_in;
         need_ff  <= need_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && held_we) held_ff[held_wa] <= in_byte;
   end

endmodule

>>> hw/rtl/sed_out.sv
// ----------------------------------------------------------------------------
// sed_out
// Result register; sends the decoded bytes of one item as successive beats.
// ----------------------------------------------------------------------------
module sed_out (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  sed_pkg::sed_result_type      res,
   output logic                         free,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [15:0]                  rsp_tdata,
   output logic                         rsp_tlast,
   output logic [0:0]                   rsp_tuser
);

   logic                          vld_ff, vld_in;
   logic [sed_pkg::IDX_W-1:0]     idx_ff, idx_in;
   sed_pkg::sed_result_type       res_ff;
   logic                          last;
   logic                          fire;
   logic [sed_pkg::BYTE_W-1:0]    cur_byte;

   assign last = (res_ff.count == '0) ||
                 ({1'b0, idx_ff} == res_ff.count - sed_pkg::CNT_W'(1));
   assign fire = vld_ff && rsp_tready;
   assign free = !vld_ff || (fire && last);
   assign cur_byte = (res_ff.count != '0) ? res_ff.bytes[idx_ff] : '0;

   always_comb begin
      vld_in = vld_ff;
      idx_in = idx_ff;
      if (load) begin
         vld_in = 1'b1;
         idx_in = '0;
      end else if (fire) begin
         if (last) vld_in = 1'b0;
         else idx_in = idx_ff + sed_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) res_ff <= res;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tlast  = last;
   assign rsp_tuser  = (res_ff.count != '0);
   assign rsp_tdata  = {2'b00, res_ff.err, res_ff.done, res_ff.consumed, cur_byte};

endmodule

>>> hw/rtl/string_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// string_escape_decoder_core
// C string escape decoder with UTF-8 output, one source byte per beat.
// ----------------------------------------------------------------------------
// Path: a request beat goes through the input register, then the result register.
// Throughput: one byte per cycle while responses are taken; an item that decodes
//   to n bytes holds the result register for n response beats, one byte each.
// Reset: synchronous; clears the escape state and both valid flags.
// ----------------------------------------------------------------------------
module string_escape_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic [0:0]  req_tuser,   // [0] end_of_source
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] consumed, [9] done_res,
                                    // [13:10] error_code, [15:14] zero
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser    // [0] byte_valid
);

   logic                    in_vld_ff;
   logic [7:0]              in_byte_ff;
   logic                    in_eos_ff;
   logic                    out_free;
   logic                    step;
   sed_pkg::sed_result_type res;

   assign step       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_eos_ff  <= req_tuser[0];
      end
   end

   sed_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .in_byte       (in_byte_ff),
      .end_of_source (in_eos_ff),
      .res           (res)
   );

   sed_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .res        (res),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_nobyte_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("beat without a byte is not last");

   a_err_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13:10] != sed_pkg::ERR_OK |-> rsp_tdata[9])
      else $error("error beat does not end the sequence");

   a_err_nobyte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13:10] != sed_pkg::ERR_OK |-> !rsp_tuser[0])
      else $error("error beat carries a byte");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !out_free |=> in_vld_ff && $stable(in_byte_ff))
      else $error("stalled input register changed");

endmodule

>>> test/tb_string_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_string_escape_decoder_core
// Self-checking bench for the string escape decoder. Escape sequences go in
// one byte per request beat: a short directed set of edge cases, then random
// sequences (mostly well formed, some corrupted or cut short, some noise)
// under changing sender gaps and receiver stalls. A scoreboard decodes each
// accepted byte on its own and checks every response beat field by field.
// ----------------------------------------------------------------------------
typedef struct packed {
   logic [7:0]                out_byte;
   logic                      byte_valid;
   logic                      last;
   logic                      consumed;
   logic                      done_res;
   logic [sed_pkg::ERR_W-1:0] error_code;
} decoded_beat_type;

class escape_decode_scoreboard;
   typedef enum logic [3:0] {
      ST_IDLE, ST_AFTER_BS, ST_CR, ST_HEX, ST_UNI, ST_OCT, ST_UTF8
   } escape_state_type;

   escape_state_type escape_state;
   logic [31:0]      code_acc;
   logic [3:0]       digits_seen;
   logic [3:0]       digits_needed;
   logic [1:0]       cont_left;
   logic [7:0]       held_bytes [4];
   decoded_beat_type expected_beats [$];
   int               failures;

   function new();
      escape_state  = ST_IDLE;
      code_acc      = '0;
      digits_seen   = '0;
      digits_needed = '0;
      cont_left     = '0;
      failures      = 0;
   endfunction

   function int outstanding();
      return expected_beats.size();
   endfunction

   function void note_request(input logic [7:0] b, input logic eos);
      logic [7:0]                out_bytes [4];
      int                        nb;
      int                        n;
      logic [sed_pkg::ERR_W-1:0] err;
      logic [3:0]                nib;
      logic                      is_hex;
      logic                      consumed;
      logic                      done;
      logic [1:0]                more;
      logic [31:0]               next_acc;
      logic [7:0]                lo;
      logic [7:0]                hi;
      decoded_beat_type          beat;
      for (int k = 0; k < 4; k++) out_bytes[k] = 8'h00;
      nb       = 0;
      err      = sed_pkg::ERR_OK;
      consumed = 1'b0;
      done     = 1'b0;
      is_hex   = 1'b1;
      nib      = b[3:0];
      if (b >= "0" && b <= "9") nib = b[3:0];
      else if (b >= "a" && b <= "f") nib = 4'(b - 8'h57);
      else if (b >= "A" && b <= "F") nib = 4'(b - 8'h37);
      else is_hex = 1'b0;

      case (escape_state)
         ST_IDLE: begin
            if (eos || b != "\\") begin
               err  = sed_pkg::ERR_NO_BACKSLASH;
               done = 1'b1;
            end else begin
               consumed     = 1'b1;
               escape_state = ST_AFTER_BS;
            end
         end
         ST_AFTER_BS: begin
            if (eos) begin
               err  = sed_pkg::ERR_INCOMPLETE;
               done = 1'b1;
            end else begin
               consumed = 1'b1;
               if (b == 8'h0A) begin
                  done = 1'b1;
               end else if (b == 8'h0D) begin
                  escape_state = ST_CR;
               end else if (b >= 8'h80) begin
                  more = 2'd0;
                  if (b >= 8'hC2 && b <= 8'hDF) more = 2'd1;
                  else if (b >= 8'hE0 && b <= 8'hEF) more = 2'd2;
                  else if (b >= 8'hF0 && b <= 8'hF4) more = 2'd3;
                  if (more == 2'd0) begin
                     err      = sed_pkg::ERR_BAD_UTF8;
                     done     = 1'b1;
                     consumed = 1'b0;
                  end else begin
                     held_bytes[0] = b;
                     digits_seen   = 4'd1;
                     cont_left     = more;
                     escape_state  = ST_UTF8;
                  end
               end else if (b == "x") begin
                  escape_state  = ST_HEX;
                  code_acc      = '0;
                  digits_seen   = '0;
                  digits_needed = 4'd2;
               end else if (b == "u" || b == "U") begin
                  escape_state  = ST_UNI;
                  code_acc      = '0;
                  digits_seen   = '0;
                  digits_needed = (b == "u") ? 4'd4 : 4'd8;
               end else if (b >= "0" && b <= "7") begin
                  escape_state = ST_OCT;
                  code_acc     = {29'd0, b[2:0]};
                  digits_seen  = 4'd1;
               end else begin
                  case (b)
                     "n": out_bytes[0] = 8'h0A;
                     "t": out_bytes[0] = 8'h09;
                     "r": out_bytes[0] = 8'h0D;
                     "b": out_bytes[0] = 8'h08;
                     "f": out_bytes[0] = 8'h0C;
                     "v": out_bytes[0] = 8'h0B;
                     "a": out_bytes[0] = 8'h07;
                     "\\", "'", "\"", "?": out_bytes[0] = b;
                     default: err = sed_pkg::ERR_BAD_ESCAPE;
                  endcase
                  nb   = (err == sed_pkg::ERR_OK) ? 1 : 0;
                  done = 1'b1;
               end
            end
         end
         ST_CR: begin
            done = 1'b1;
            if (!eos && b == 8'h0A) consumed = 1'b1;
            else err = sed_pkg::ERR_BAD_ESCAPE;
         end
         ST_HEX, ST_UNI: begin
            if (eos) begin
               err  = (escape_state == ST_HEX) ? sed_pkg::ERR_HEX_SHORT
                                               : sed_pkg::ERR_UNI_SHORT;
               done = 1'b1;
            end else if (!is_hex) begin
               err  = (escape_state == ST_HEX) ? sed_pkg::ERR_BAD_HEX
                                               : sed_pkg::ERR_BAD_UNI_HEX;
               done = 1'b1;
            end else begin
               consumed    = 1'b1;
               code_acc    = {code_acc[27:0], nib};
               digits_seen = digits_seen + 4'd1;
               if (digits_seen >= digits_needed) begin
                  done = 1'b1;
                  if (escape_state == ST_HEX) begin
                     out_bytes[0] = code_acc[7:0];
                     nb           = 1;
                  end else if (code_acc >= 32'hD800 && code_acc <= 32'hDFFF) begin
                     err = sed_pkg::ERR_SURROGATE;
                  end else if (code_acc > 32'h10FFFF) begin
                     err = sed_pkg::ERR_RANGE;
                  end else if (code_acc < 32'h80) begin
                     out_bytes[0] = code_acc[7:0];
                     nb           = 1;
                  end else if (code_acc < 32'h800) begin
                     out_bytes[0] = {3'b110, code_acc[10:6]};
                     out_bytes[1] = {2'b10, code_acc[5:0]};
                     nb           = 2;
                  end else if (code_acc < 32'h10000) begin
                     out_bytes[0] = {4'b1110, code_acc[15:12]};
                     out_bytes[1] = {2'b10, code_acc[11:6]};
                     out_bytes[2] = {2'b10, code_acc[5:0]};
                     nb           = 3;
                  end else begin
                     out_bytes[0] = {5'b11110, code_acc[20:18]};
                     out_bytes[1] = {2'b10, code_acc[17:12]};
                     out_bytes[2] = {2'b10, code_acc[11:6]};
                     out_bytes[3] = {2'b10, code_acc[5:0]};
                     nb           = 4;
                  end
               end
            end
         end
         ST_OCT: begin
            done = 1'b1;
            if (!eos && b >= "0" && b <= "7") begin
               next_acc = {code_acc[28:0], b[2:0]};
               if (next_acc <= 32'd255) begin
                  code_acc    = next_acc;
                  digits_seen = digits_seen + 4'd1;
                  consumed    = 1'b1;
                  if (digits_seen < 4'd3) done = 1'b0;
               end
            end
            if (done) begin
               out_bytes[0] = code_acc[7:0];
               nb           = 1;
            end
         end
         ST_UTF8: begin
            lo = 8'h80;
            hi = 8'hBF;
            if (eos) begin
               err  = sed_pkg::ERR_BAD_UTF8;
               done = 1'b1;
            end else begin
               if (digits_seen == 4'd1) begin
                  if (held_bytes[0] == 8'hE0) lo = 8'hA0;
                  else if (held_bytes[0] == 8'hED) hi = 8'h9F;
                  else if (held_bytes[0] == 8'hF0) lo = 8'h90;
                  else if (held_bytes[0] == 8'hF4) hi = 8'h8F;
               end
               if (b < lo || b > hi || digits_seen >= 4'd4 || cont_left == 2'd0) begin
                  err  = sed_pkg::ERR_BAD_UTF8;
                  done = 1'b1;
               end else begin
                  consumed                    = 1'b1;
                  held_bytes[digits_seen[1:0]] = b;
                  digits_seen                 = digits_seen + 4'd1;
                  cont_left                   = cont_left - 2'd1;
                  if (cont_left == 2'd0) begin
                     for (int k = 0; k < 4; k++)
                        if (k < int'(digits_seen)) out_bytes[k] = held_bytes[k];
                     nb   = int'(digits_seen);
                     done = 1'b1;
                  end
               end
            end
         end
         default: done = 1'b1;
      endcase

      if (done) begin
         escape_state  = ST_IDLE;
         code_acc      = '0;
         digits_seen   = '0;
         digits_needed = '0;
         cont_left     = '0;
      end

      n = (nb != 0) ? nb : 1;
      for (int k = 0; k < n; k++) begin
         beat.out_byte   = (k < nb) ? out_bytes[k] : 8'h00;
         beat.byte_valid = (k < nb);
         beat.last       = (k == n - 1);
         beat.consumed   = consumed;
         beat.done_res   = done;
         beat.error_code = err;
         expected_beats.push_back(beat);
      end
   endfunction

   function void check_response(input logic [15:0] data, input logic tlast,
                                input logic tuser);
      decoded_beat_type exp_beat;
      if (expected_beats.size() == 0) begin
         $error("unexpected response beat: tdata %h", data);
         failures++;
         return;
      end
      exp_beat = expected_beats.pop_front();
      if (data[7:0] !== exp_beat.out_byte) begin
         $error("out_byte mismatch: expected %0h, actual %0h",
                exp_beat.out_byte, data[7:0]);
         failures++;
      end
      if (tuser !== exp_beat.byte_valid) begin
         $error("byte_valid mismatch: expected %0d, actual %0d",
                exp_beat.byte_valid, tuser);
         failures++;
      end
      if (tlast !== exp_beat.last) begin
         $error("last mismatch: expected %0d, actual %0d", exp_beat.last, tlast);
         failures++;
      end
      if (data[8] !== exp_beat.consumed) begin
         $error("consumed mismatch: expected %0d, actual %0d",
                exp_beat.consumed, data[8]);
         failures++;
      end
      if (data[9] !== exp_beat.done_res) begin
         $error("done_res mismatch: expected %0d, actual %0d",
                exp_beat.done_res, data[9]);
         failures++;
      end
      if (data[13:10] !== exp_beat.error_code) begin
         $error("error_code mismatch: expected %0d, actual %0d",
                exp_beat.error_code, data[13:10]);
         failures++;
      end
   endfunction
endclass

module tb_string_escape_decoder_core;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int PHASE_ITEMS    = 20;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] in_byte
   logic [0:0]  req_tuser;    // [0] end_of_source
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;    // [7:0] out_byte, [8] consumed, [9] done_res,
                              // [13:10] error_code, [15:14] zero
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;    // [0] byte_valid

   int idle_pct  = 0;
   int stall_pct = 0;
   int quiet_cycles;

   escape_decode_scoreboard sb;

   string_escape_decoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tlast, rsp_tuser[0]);
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + {4'd0, v};
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eos);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= eos;
      do @(posedge clock); while (!req_tready);
      sb.note_request(b, eos);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Build and send one escape sequence, bytes in [7:0] and end-of-source in [8].
   task automatic send_random_escape(output int sent);
      logic [8:0]  seq [$];
      logic [31:0] cp;
      logic [7:0]  lead;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [7:0]  lead_edges [4];
      int          ncont;
      int          pos;
      string       simple;
      simple        = "ntrbfva\\'\"?";
      lead_edges[0] = 8'hE0;
      lead_edges[1] = 8'hED;
      lead_edges[2] = 8'hF0;
      lead_edges[3] = 8'hF4;
      seq.push_back({1'b0, 8'h5C});
      case ($urandom_range(0, 9))
         0, 9: begin
            if ($urandom_range(0, 3) == 0) seq.push_back({1'b0, 8'($urandom_range(0, 255))});
            else seq.push_back({1'b0, simple[$urandom_range(0, 10)]});
         end
         1: begin
            seq.push_back({1'b0, 8'h78});
            repeat (2) seq.push_back({1'b0, hex_char(4'($urandom_range(0, 15)))});
         end
         2: begin
            case ($urandom_range(0, 4))
               0: cp = $urandom_range(0, 'h7F);
               1: cp = $urandom_range('h80, 'h7FF);
               2: cp = $urandom_range('h800, 'hFFFF);
               3: cp = $urandom_range('hD800, 'hDFFF);
               default: begin
                  case ($urandom_range(0, 5))
                     0: cp = 32'h7F;
                     1: cp = 32'h80;
                     2: cp = 32'h7FF;
                     3: cp = 32'h800;
                     4: cp = 32'hD7FF;
                     default: cp = 32'hE000;
                  endcase
               end
            endcase
            seq.push_back({1'b0, 8'h75});
            for (int i = 3; i >= 0; i--) seq.push_back({1'b0, hex_char(cp[4*i +: 4])});
         end
         3: begin
            case ($urandom_range(0, 4))
               0: cp = $urandom_range('h10000, 'h10FFFF);
               1: cp = $urandom();
               2: cp = $urandom_range(0, 'hFFFF);
               3: cp = $urandom_range('h110000, 'h1FFFFF);
               default: begin
                  case ($urandom_range(0, 3))
                     0: cp = 32'h10FFFF;
                     1: cp = 32'h110000;
                     2: cp = 32'hFFFFFFFF;
                     default: cp = 32'h0;
                  endcase
               end
            endcase
            seq.push_back({1'b0, 8'h55});
            for (int i = 7; i >= 0; i--) seq.push_back({1'b0, hex_char(cp[4*i +: 4])});
         end
         4: begin
            repeat ($urandom_range(1, 3)) seq.push_back({1'b0, 8'h30 + 8'($urandom_range(0, 7))});
            case ($urandom_range(0, 2))
               0: ;
               1: seq.push_back({1'b0, 8'h30 + 8'($urandom_range(0, 7))});
               default: seq.push_back({1'b0, 8'($urandom_range(0, 255))});
            endcase
         end
         5: begin
            case ($urandom_range(0, 3))
               0: seq.push_back({1'b0, 8'h0A});
               1: begin
                  seq.push_back({1'b0, 8'h0D});
                  seq.push_back({1'b0, 8'h0A});
               end
               2: begin
                  seq.push_back({1'b0, 8'h0D});
                  seq.push_back({1'b0, 8'($urandom_range(0, 255))});
               end
               default: begin
                  seq.push_back({1'b0, 8'h0D});
                  seq.push_back({1'b1, 8'($urandom_range(0, 255))});
               end
            endcase
         end
         6, 7: begin
            case ($urandom_range(0, 3))
               0: lead = 8'($urandom_range('hC2, 'hDF));
               1: lead = 8'($urandom_range('hE0, 'hEF));
               2: lead = 8'($urandom_range('hF0, 'hF4));
               default: lead = lead_edges[$urandom_range(0, 3)];
            endcase
            ncont = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
            lo = 8'h80;
            hi = 8'hBF;
            if (lead == 8'hE0) lo = 8'hA0;
            else if (lead == 8'hED) hi = 8'h9F;
            else if (lead == 8'hF0) lo = 8'h90;
            else if (lead == 8'hF4) hi = 8'h8F;
            seq.push_back({1'b0, lead});
            seq.push_back({1'b0, 8'($urandom_range(lo, hi))});
            repeat (ncont - 1) seq.push_back({1'b0, 8'($urandom_range('h80, 'hBF))});
         end
         default: begin
            seq.delete();
            seq.push_back({($urandom_range(0, 2) == 0), 8'($urandom_range(0, 255))});
         end
      endcase
      // now and then corrupt one beat, and sometimes cut the sequence there
      if (seq.size() >= 2 && $urandom_range(0, 5) == 0) begin
         pos      = $urandom_range(1, seq.size() - 1);
         seq[pos] = {($urandom_range(0, 4) == 0), 8'($urandom_range(0, 255))};
         if ($urandom_range(0, 1) == 1)
            while (seq.size() > pos + 1) void'(seq.pop_back());
      end
      sent = seq.size();
      foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
   endtask

   initial begin
      logic [8:0] directed [$];
      int         phase_items;
      int         sent;
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = 1'b0;
      directed = {9'h041,                          // plain byte while idle
                  9'h100,                          // end of source while idle
                  9'h05C, 9'h100,                  // cut right after backslash
                  9'h05C, 9'h06E,                  // \n
                  9'h05C, 9'h00D, 9'h041,          // CR then a non-LF byte
                  9'h05C, 9'h078, 9'h046, 9'h066,  // \xFf
                  9'h05C, 9'h033, 9'h037, 9'h037,  // \377
                  9'h05C, 9'h075, 9'h044, 9'h046, 9'h046, 9'h046,  // \uDFFF
                  9'h05C, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF};         // raw U+10FFFF
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 49; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 49; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            send_random_escape(sent);
            phase_items += sent;
         end
         drain_responses();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
